// File: src/scc_pkg.sv
// ============================================================================
// scc_pkg: shared types for the source record counter and classifier
// Entry and cell control structures, verdict codes and controller states.
// ============================================================================
package scc_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic              valid;
    } entry_t;

    typedef struct packed {
        logic              rotate;
        logic              record;
        logic              insert;
        logic [ADDR_W-1:0] addr;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_POSSIBLE = 2'd1,
        VERDICT_LIKELY   = 2'd2,
        VERDICT_DROP     = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef enum logic {
        REG_LIKELY   = 1'b0,
        REG_POSSIBLE = 1'b1
    } reg_index_t;

endpackage

// File: src/scc_cell.sv
// ============================================================================
// scc_cell: one table entry of the counter chain
// Holds a key and its count, matches a record address, counts hits, takes
// an insert when it is the first free entry, and shifts toward its neighbor.
// ============================================================================
module scc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  scc_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    input  scc_pkg::entry_t     nbr,
    output scc_pkg::entry_t     entry,
    output logic                match
);
    import scc_pkg::*;

    logic [ADDR_W-1:0] key_reg;
    logic [ADDR_W-1:0] key_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              valid_reg;
    logic              valid_next;

    assign match = valid_reg && (key_reg == ctrl.addr);

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (ctrl.rotate)
        begin
            key_next   = nbr.key;
            count_next = nbr.count;
            valid_next = nbr.valid;
        end
        else if (ctrl.record && match)
        begin
            if (count_reg != CNT_MAX)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (ctrl.insert && !valid_reg && prev_valid)
        begin
            key_next   = ctrl.addr;
            count_next = CNT_W'(1);
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign entry.key   = key_reg;
    assign entry.count = count_reg;
    assign entry.valid = valid_reg;

endmodule

// File: src/source_record_counter_classifier_core.sv
// ============================================================================
// source_record_counter_classifier_core: per-source record counter
// Counts records per source address in a chain of cells and reports the
// entries whose counts reach the likely or possible thresholds, and drops new sources when the table is full.
// ============================================================================
// A record item is taken while the output register is free, and a drop result
// shows in the cycle after it. Records sustain one item per cycle while the
// output register is free. A report item rotates the cell chain through all
// entries, holding while a qualifying head waits on a busy output register,
// then flushes its last result when the output register is free. Reset clears
// all entry valid bits, the thresholds, the pending and output valid bits.
module source_record_counter_classifier_core
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // src_addr[31:0]
    input  logic        s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_addr[31:0], record_count[47:32]
    output logic [1:0]  m_tuser,   // verdict[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import scc_pkg::*;

    localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_DEPTH - 1);

    state_t state_reg;
    state_t state_next;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0]  likely_reg;
    logic [CNT_W-1:0]  possible_reg;

    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic [CNT_W-1:0]  pend_count_reg;
    logic [CNT_W-1:0]  pend_count_next;
    verdict_t          pend_verdict_reg;
    verdict_t          pend_verdict_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [ADDR_W-1:0] m_addr_next;
    logic [CNT_W-1:0]  m_count_reg;
    logic [CNT_W-1:0]  m_count_next;
    verdict_t          m_verdict_reg;
    verdict_t          m_verdict_next;
    logic              m_last_reg;
    logic              m_last_next;

    cell_ctrl_t              ctrl;
    entry_t                  cell_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  cell_match;
    logic [TABLE_DEPTH-1:0]  valid_vec;

    logic     any_hit;
    logic     full;
    logic     out_free;
    logic     in_accept;
    logic     is_report;
    logic     head_likely;
    logic     head_possible;
    logic     head_qualify;
    verdict_t head_verdict;
    logic     walk_stall;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic prev_valid;
            if (gi == 0)
            begin : g_first
                assign prev_valid = 1'b1;
            end
            else
            begin : g_rest
                assign prev_valid = cell_q[gi-1].valid;
            end

            scc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (prev_valid),
                .nbr        (cell_q[(gi + 1) % TABLE_DEPTH]),
                .entry      (cell_q[gi]),
                .match      (cell_match[gi])
            );

            assign valid_vec[gi] = cell_q[gi].valid;
        end
    endgenerate

    assign any_hit   = |cell_match;
    assign full      = cell_q[TABLE_DEPTH-1].valid;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign is_report = s_tuser;

    assign head_likely   = cell_q[0].count >= likely_reg;
    assign head_possible = cell_q[0].count >= possible_reg;
    assign head_qualify  = cell_q[0].valid && (head_likely || head_possible);
    assign head_verdict  = head_likely ? VERDICT_LIKELY : VERDICT_POSSIBLE;
    assign walk_stall    = head_qualify && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && is_report)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!walk_stall && step_reg == STEP_LAST)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready          = 1'b0;
        ctrl.rotate       = 1'b0;
        ctrl.record       = 1'b0;
        ctrl.insert       = 1'b0;
        ctrl.addr         = s_tdata;
        step_next         = step_reg;
        pend_valid_next   = pend_valid_reg;
        pend_addr_next    = pend_addr_reg;
        pend_count_next   = pend_count_reg;
        pend_verdict_next = pend_verdict_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_addr_next       = m_addr_reg;
        m_count_next      = m_count_reg;
        m_verdict_next    = m_verdict_reg;
        m_last_next       = m_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (in_accept)
                begin
                    if (is_report)
                    begin
                        step_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        ctrl.record = 1'b1;
                        ctrl.insert = !any_hit;
                        if (!any_hit && full)
                        begin
                            m_valid_next   = 1'b1;
                            m_addr_next    = s_tdata;
                            m_count_next   = '0;
                            m_verdict_next = VERDICT_DROP;
                            m_last_next    = 1'b1;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (!walk_stall)
                begin
                    ctrl.rotate = 1'b1;
                    step_next   = step_reg + STEP_W'(1);
                    if (head_qualify)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_valid_next   = 1'b1;
                            m_addr_next    = pend_addr_reg;
                            m_count_next   = pend_count_reg;
                            m_verdict_next = pend_verdict_reg;
                            m_last_next    = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_addr_next    = cell_q[0].key;
                        pend_count_next   = cell_q[0].count;
                        pend_verdict_next = head_verdict;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        m_addr_next    = pend_addr_reg;
                        m_count_next   = pend_count_reg;
                        m_verdict_next = pend_verdict_reg;
                    end
                    else
                    begin
                        m_addr_next    = '0;
                        m_count_next   = '0;
                        m_verdict_next = VERDICT_NONE;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            likely_reg     <= '0;
            possible_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_LIKELY:   likely_reg   <= cfg_data;
                    REG_POSSIBLE: possible_reg <= cfg_data;
                    default:      likely_reg   <= likely_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg    <= pend_addr_next;
        pend_count_reg   <= pend_count_next;
        pend_verdict_reg <= pend_verdict_next;
        m_addr_reg       <= m_addr_next;
        m_count_reg      <= m_count_next;
        m_verdict_reg    <= m_verdict_next;
        m_last_reg       <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_addr_reg};
    assign m_tuser  = m_verdict_reg;
    assign m_tlast  = m_last_reg;

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_match))
        else $error("more than one cell matches the record address");

    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            $onehot0(valid_vec + TABLE_DEPTH'(1)) || (valid_vec == '1))
        else $error("valid entries are not packed from the chain head");

    a_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_vec) >= $past($countones(valid_vec)))
        else $error("table lost an entry");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending report result left over after a walk");

endmodule
